@@ rtl/core/i2cm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the I2C master bit sequencer.
// No dependencies; every other file in rtl/core imports this package.
package i2cm_pkg;

    // Width of the delay and acknowledge poll counters.
    localparam int COUNT_WIDTH = 16;
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam int CFG_ADDR_WIDTH = 8;
    localparam int CFG_DATA_WIDTH = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_HALF_BIT_DELAY = 8'd0,
        REG_ACK_TIMEOUT    = 8'd1
    } cfg_reg_t;

    localparam logic [15:0] HALF_BIT_DELAY_RST = 16'd50;
    localparam logic [15:0] ACK_TIMEOUT_RST    = 16'd1000;

    // Command opcodes; code 7 means nothing and is ignored.
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_WACK  = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_BUS_BUSY = 2'd1,
        ERR_ACK_TO   = 2'd2
    } err_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] write_byte;
        logic       scl_in;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_seen;
        logic [1:0] error_code;
    } res_item_t;

    typedef struct packed {
        logic [15:0] half_bit_delay;
        logic [15:0] ack_timeout;
    } cfg_t;

    // A zero register acts as one; values saturate at the counter range.
    function automatic count_t clip(input logic [15:0] v);
        logic [31:0] x;
        x = (v == 16'd0) ? 32'd1 : 32'(v);
        if (x > CNT_MAX)
        begin
            x = CNT_MAX;
        end
        return x[COUNT_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/core/i2cm_channels.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces: command requests, results, config writes.
// Depends on i2cm_pkg.
interface i2cm_cmd_if;
    import i2cm_pkg::*;
    logic      valid;
    logic      ready;
    cmd_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_res_if;
    import i2cm_pkg::*;
    logic      valid;
    logic      ready;
    res_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cm_cfg_if;
    import i2cm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_ADDR_WIDTH-1:0] addr;
    logic [CFG_DATA_WIDTH-1:0] wdata;
    modport source (output valid, output addr, output wdata, input ready);
    modport sink   (input valid, input addr, input wdata, output ready);
endinterface

@@ rtl/core/i2cm_seq.sv @@
`timescale 1ns / 1ps
// Bit sequencer: phase machine, counters, shift register and line drives.
// Advances one tick per step_en. Depends on i2cm_pkg.
module i2cm_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  i2cm_pkg::cmd_item_t item,
    input  i2cm_pkg::cfg_t      cfg,
    output i2cm_pkg::res_item_t result
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_CHECK, PH_ST_SCLL, PH_ST_END, PH_SP_END,
        PH_WR_SCLH, PH_WR_SCLL, PH_WR_NEXT, PH_RD_SAMPLE, PH_RD_NEXT,
        PH_WA_SCLH, PH_WA_POLLGO, PH_WA_POLL, PH_WA_ACKEND, PH_WA_STOPEND,
        PH_AK_SCLH, PH_AK_SCLL, PH_AK_END
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    count_t      delay_reg, delay_next;
    count_t      poll_reg, poll_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        ack_reg, ack_next;
    logic [1:0]  err_reg, err_next;
    logic        done_reg, done_next;

    count_t      delay_dec;
    count_t      poll_inc;
    count_t      hb_delay;
    logic [3:0]  bit_cnt_inc;

    assign hb_delay    = clip(cfg.half_bit_delay);
    assign delay_dec   = (delay_reg != '0) ? delay_reg - count_t'(1) : delay_reg;
    assign poll_inc    = (32'(poll_reg) < CNT_MAX) ? poll_reg + count_t'(1) : poll_reg;
    assign bit_cnt_inc = bit_cnt_reg + 4'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        bit_cnt_next = bit_cnt_reg;
        delay_next   = delay_reg;
        poll_next    = poll_reg;
        shift_next   = shift_reg;
        rbyte_next   = rbyte_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        ack_next     = ack_reg;
        err_next     = err_reg;
        done_next    = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            if (item.cmd_valid && (item.opcode <= OP_NACK))
            begin
                cmd_next     = item.opcode;
                err_next     = ERR_NONE;
                bit_cnt_next = '0;
                poll_next    = '0;
                delay_next   = hb_delay;
                unique case (opcode_t'(item.opcode))
                    OP_START:
                    begin
                        sda_next = 1'b1; scl_next = 1'b1; phase_next = PH_ST_CHECK;
                    end
                    OP_STOP:
                    begin
                        sda_next = 1'b0; scl_next = 1'b1; phase_next = PH_SP_END;
                    end
                    OP_WRITE:
                    begin
                        shift_next = item.write_byte;
                        sda_next   = item.write_byte[7];
                        phase_next = PH_WR_SCLH;
                    end
                    OP_READ:
                    begin
                        shift_next = '0; scl_next = 1'b1; phase_next = PH_RD_SAMPLE;
                    end
                    OP_WACK:
                    begin
                        sda_next = 1'b1; phase_next = PH_WA_SCLH;
                    end
                    OP_ACK:
                    begin
                        sda_next = 1'b0; phase_next = PH_AK_SCLH;
                    end
                    default:
                    begin
                        sda_next = 1'b1; phase_next = PH_AK_SCLH;
                    end
                endcase
            end
        end
        else
        begin
            // Poll phase always sits at delay zero, so it fires every tick.
            delay_next = delay_dec;
            if (delay_dec == '0)
            begin
                unique case (phase_reg)
                    PH_ST_CHECK:
                    begin
                        if (!(item.scl_in && item.sda_in))
                        begin
                            err_next   = ERR_BUS_BUSY;
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            sda_next = 1'b0; delay_next = hb_delay; phase_next = PH_ST_SCLL;
                        end
                    end
                    PH_ST_SCLL:
                    begin
                        scl_next = 1'b0; delay_next = hb_delay; phase_next = PH_ST_END;
                    end
                    PH_SP_END:
                    begin
                        sda_next = 1'b1; phase_next = PH_IDLE; done_next = 1'b1;
                    end
                    PH_WR_SCLH:
                    begin
                        scl_next = 1'b1; delay_next = hb_delay; phase_next = PH_WR_SCLL;
                    end
                    PH_WR_SCLL:
                    begin
                        scl_next = 1'b0;
                        if (bit_cnt_reg >= 4'd7)
                        begin
                            sda_next = 1'b1;
                        end
                        shift_next = {shift_reg[6:0], 1'b0};
                        delay_next = hb_delay;
                        phase_next = PH_WR_NEXT;
                    end
                    PH_WR_NEXT:
                    begin
                        bit_cnt_next = bit_cnt_inc;
                        if (bit_cnt_inc >= 4'd8)
                        begin
                            phase_next = PH_IDLE; done_next = 1'b1;
                        end
                        else
                        begin
                            sda_next   = shift_reg[7];
                            delay_next = hb_delay;
                            phase_next = PH_WR_SCLH;
                        end
                    end
                    PH_RD_SAMPLE:
                    begin
                        shift_next = {shift_reg[6:0], item.sda_in};
                        scl_next   = 1'b0;
                        delay_next = hb_delay;
                        phase_next = PH_RD_NEXT;
                    end
                    PH_RD_NEXT:
                    begin
                        bit_cnt_next = bit_cnt_inc;
                        if (bit_cnt_inc >= 4'd8)
                        begin
                            rbyte_next = shift_reg; phase_next = PH_IDLE; done_next = 1'b1;
                        end
                        else
                        begin
                            scl_next = 1'b1; delay_next = hb_delay; phase_next = PH_RD_SAMPLE;
                        end
                    end
                    PH_WA_SCLH:
                    begin
                        scl_next = 1'b1; delay_next = hb_delay; phase_next = PH_WA_POLLGO;
                    end
                    PH_WA_POLLGO, PH_WA_POLL:
                    begin
                        if (!item.sda_in)
                        begin
                            ack_next   = 1'b1;
                            scl_next   = 1'b0;
                            delay_next = hb_delay;
                            phase_next = PH_WA_ACKEND;
                        end
                        else
                        begin
                            poll_next = poll_inc;
                            if (poll_inc >= clip(cfg.ack_timeout))
                            begin
                                // Timeout: report nack, then play a stop.
                                ack_next   = 1'b0;
                                err_next   = ERR_ACK_TO;
                                sda_next   = 1'b0;
                                scl_next   = 1'b1;
                                delay_next = hb_delay;
                                phase_next = PH_WA_STOPEND;
                            end
                            else
                            begin
                                phase_next = PH_WA_POLL;
                            end
                        end
                    end
                    PH_WA_STOPEND:
                    begin
                        sda_next = 1'b1; phase_next = PH_IDLE; done_next = 1'b1;
                    end
                    PH_AK_SCLH:
                    begin
                        scl_next = 1'b1; delay_next = hb_delay; phase_next = PH_AK_SCLL;
                    end
                    PH_AK_SCLL:
                    begin
                        scl_next = 1'b0; delay_next = hb_delay; phase_next = PH_AK_END;
                    end
                    PH_AK_END:
                    begin
                        if (cmd_reg == OP_ACK)
                        begin
                            sda_next = 1'b1;
                        end
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE; done_next = 1'b1;
                    end
                endcase
            end
            if (done_next)
            begin
                bit_cnt_next = '0;
                poll_next    = '0;
                delay_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cmd_reg     <= '0;
            bit_cnt_reg <= '0;
            delay_reg   <= '0;
            poll_reg    <= '0;
            shift_reg   <= '0;
            rbyte_reg   <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            ack_reg     <= 1'b0;
            err_reg     <= ERR_NONE;
            done_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            bit_cnt_reg <= bit_cnt_next;
            delay_reg   <= delay_next;
            poll_reg    <= poll_next;
            shift_reg   <= shift_next;
            rbyte_reg   <= rbyte_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            ack_reg     <= ack_next;
            err_reg     <= err_next;
            done_reg    <= done_next;
        end
    end

    assign result.scl_out    = scl_reg;
    assign result.sda_out    = sda_reg;
    assign result.busy_res   = (phase_reg != PH_IDLE);
    assign result.done_res   = done_reg;
    assign result.read_byte  = rbyte_reg;
    assign result.ack_seen   = ack_reg;
    assign result.error_code = err_reg;

endmodule

@@ rtl/core/i2c_master_bit_sequencer_core.sv @@
`timescale 1ns / 1ps
// Top level of the I2C master bit sequencer: channel handshakes, input
// register, config registers. Depends on i2cm_pkg, i2cm_channels, i2cm_seq.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  cmd     | in  | valid / ready | cmd_valid, opcode, write_byte, scl_in, sda_in
//  res     | out | valid / ready | scl_out, sda_out, busy_res, done_res,
//          |     |               | read_byte, ack_seen, error_code
//  cfg     | in  | valid / ready | addr (0 half_bit_delay, 1 ack_timeout), wdata
//
// One request in, one result out; a new request is taken every cycle unless
// res stalls. Each request passes the input register, then the sequencer
// state and result register, with one short step of next-state logic between.
// A stalled res channel holds the result; the input register then fills and
// cmd.ready drops until the result is taken.
// Reset clears the sequencer to idle with both lines released and loads the
// config registers with 50 and 1000. cfg.ready is always high.
module i2c_master_bit_sequencer_core (
    input  logic clk,
    input  logic rst_n,
    i2cm_cmd_if.sink   cmd,
    i2cm_res_if.source res,
    i2cm_cfg_if.sink   cfg
);
    import i2cm_pkg::*;

    logic      in_valid_reg;
    cmd_item_t in_item_reg;
    logic      out_valid_reg;
    logic      step_en;
    cfg_t      cfg_reg;
    res_item_t seq_result;

    // The step may run when the result slot is empty or being emptied.
    assign step_en   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || step_en;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload register, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_item_reg <= cmd.data;
        end
    end

    // Config registers; writes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_bit_delay <= HALF_BIT_DELAY_RST;
            cfg_reg.ack_timeout    <= ACK_TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.addr == REG_HALF_BIT_DELAY)
            begin
                cfg_reg.half_bit_delay <= cfg.wdata;
            end
            else if (cfg.addr == REG_ACK_TIMEOUT)
            begin
                cfg_reg.ack_timeout <= cfg.wdata;
            end
        end
    end

    i2cm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (seq_result)
    );

    assign res.valid = out_valid_reg;
    assign res.data  = seq_result;

endmodule

@@ verif/tb_i2c_master_bit_sequencer_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for i2c_master_bit_sequencer_core: line-level I2C command
// sequences with a cycle-exact predictor. Needs i2cm_pkg, i2cm_channels, the RTL.
module tb_i2c_master_bit_sequencer_core;
    import i2cm_pkg::*;

    // Opcode 7 carries no command; the sequencer must ignore it.
    localparam logic [2:0] OP_NOP = 3'd7;

    // Largest value the delay and poll counters can hold.
    localparam logic [31:0] COUNT_TOP = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    // Sequencer steps; each names the line change that is due when the
    // running delay reaches zero.
    typedef enum logic [4:0] {
        SQ_IDLE,
        SQ_ST_CHECK,
        SQ_ST_SCLL,
        SQ_ST_END,
        SQ_SP_END,
        SQ_WR_SCLH,
        SQ_WR_SCLL,
        SQ_WR_NEXT,
        SQ_RD_SAMPLE,
        SQ_RD_NEXT,
        SQ_WA_SCLH,
        SQ_WA_POLLGO,
        SQ_WA_POLL,
        SQ_WA_ACKEND,
        SQ_WA_STOPEND,
        SQ_AK_SCLH,
        SQ_AK_SCLL,
        SQ_AK_END
    } seq_state_t;

    // How the sampled bus levels of filler requests are shaped.
    typedef enum logic [1:0] {
        LN_FREE,      // random levels
        LN_BUS_IDLE,  // both lines high
        LN_BUS_LOW,   // at least one line low
        LN_ACK_AT     // SCL high, SDA high until a chosen tick, then low
    } line_mode_t;

    logic clk;
    logic rst_n;

    i2cm_cmd_if cmd_ch ();
    i2cm_res_if res_ch ();
    i2cm_cfg_if cfg_ch ();

    i2c_master_bit_sequencer_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the sequencer and its registers.
    // Updated once per accepted request, in the driver block.
    // ------------------------------------------------------------------
    logic [15:0] hbd_reg   = HALF_BIT_DELAY_RST;
    logic [15:0] ackto_reg = ACK_TIMEOUT_RST;

    seq_state_t  sq_state = SQ_IDLE;
    opcode_t     sq_op    = OP_START;
    logic [3:0]  sq_bits  = '0;
    logic [31:0] sq_delay = '0;
    logic [31:0] sq_polls = '0;
    logic [7:0]  sq_shift = '0;
    logic [7:0]  sq_rx    = '0;
    logic        sq_scl   = 1'b1;
    logic        sq_sda   = 1'b1;
    logic        sq_ack   = 1'b0;
    err_t        sq_err   = ERR_NONE;
    logic        sq_done  = 1'b0;

    // Stimulus and scoreboard.
    cmd_item_t pending_reqs[$];     // requests waiting for the driver
    res_item_t expected_lines[$];   // predicted results, oldest first
    int        reqs_pushed = 0;
    int        reqs_taken  = 0;
    int        cmds_issued = 0;
    int        results_seen = 0;
    int        fail_count  = 0;

    line_mode_t line_mode = LN_FREE;
    int         ack_at    = 0;
    int         tick_no   = 0;
    int         noise_pct = 0;

    int          burst_left = 1;
    int          gap_left   = 0;
    logic [31:0] stall_clock = '0;
    res_item_t   want;
    res_item_t   got;

    // Register value to tick count: zero behaves as one, saturate at counter.
    function automatic logic [31:0] ticks_of(logic [15:0] v);
        logic [31:0] n;
        n = (v == 16'd0) ? 32'd1 : {16'd0, v};
        return (n > COUNT_TOP) ? COUNT_TOP : n;
    endfunction

    function automatic void hold_then(seq_state_t nxt);
        sq_delay = ticks_of(hbd_reg);
        sq_state = nxt;
    endfunction

    function automatic void end_cmd();
        sq_state = SQ_IDLE;
        sq_bits  = '0;
        sq_polls = '0;
        sq_delay = '0;
        sq_done  = 1'b1;
    endfunction

    // One SDA sample during wait-ack. Low = ack; otherwise count toward the
    // timeout, which then plays the stop sequence.
    function automatic void ack_poll(logic sda);
        if (!sda)
        begin
            sq_ack = 1'b1;
            sq_scl = 1'b0;
            hold_then(SQ_WA_ACKEND);
        end
        else
        begin
            if (sq_polls < COUNT_TOP)
            begin
                sq_polls++;
            end
            if (sq_polls >= ticks_of(ackto_reg))
            begin
                sq_ack = 1'b0;
                sq_err = ERR_ACK_TO;
                sq_sda = 1'b0;
                sq_scl = 1'b1;
                hold_then(SQ_WA_STOPEND);
            end
            else
            begin
                sq_state = SQ_WA_POLL;
            end
        end
    endfunction

    function automatic void launch(opcode_t op, logic [7:0] wb);
        sq_op    = op;
        sq_err   = ERR_NONE;
        sq_bits  = '0;
        sq_polls = '0;
        case (op)
            OP_START:
            begin
                sq_sda = 1'b1;
                sq_scl = 1'b1;
                hold_then(SQ_ST_CHECK);
            end
            OP_STOP:
            begin
                sq_sda = 1'b0;
                sq_scl = 1'b1;
                hold_then(SQ_SP_END);
            end
            OP_WRITE:
            begin
                sq_shift = wb;
                sq_sda   = wb[7];
                hold_then(SQ_WR_SCLH);
            end
            OP_READ:
            begin
                sq_shift = '0;
                sq_scl   = 1'b1;
                hold_then(SQ_RD_SAMPLE);
            end
            OP_WACK:
            begin
                sq_sda = 1'b1;
                hold_then(SQ_WA_SCLH);
            end
            OP_ACK:
            begin
                sq_sda = 1'b0;
                hold_then(SQ_AK_SCLH);
            end
            default:
            begin
                sq_sda = 1'b1;
                hold_then(SQ_AK_SCLH);
            end
        endcase
    endfunction

    // Line change due when the delay of the current step runs out.
    function automatic void advance(logic scl, logic sda);
        case (sq_state)
            SQ_ST_CHECK:
            begin
                if (!(scl && sda))
                begin
                    // bus not idle: give up, lines stay released
                    sq_err = ERR_BUS_BUSY;
                    end_cmd();
                end
                else
                begin
                    sq_sda = 1'b0;
                    hold_then(SQ_ST_SCLL);
                end
            end
            SQ_ST_SCLL:
            begin
                sq_scl = 1'b0;
                hold_then(SQ_ST_END);
            end
            SQ_ST_END:
            begin
                end_cmd();
            end
            SQ_SP_END:
            begin
                sq_sda = 1'b1;
                end_cmd();
            end
            SQ_WR_SCLH:
            begin
                sq_scl = 1'b1;
                hold_then(SQ_WR_SCLL);
            end
            SQ_WR_SCLL:
            begin
                sq_scl = 1'b0;
                if (sq_bits >= 4'd7)
                begin
                    sq_sda = 1'b1;  // release SDA after the last bit
                end
                sq_shift = {sq_shift[6:0], 1'b0};
                hold_then(SQ_WR_NEXT);
            end
            SQ_WR_NEXT:
            begin
                sq_bits = sq_bits + 4'd1;
                if (sq_bits >= 4'd8)
                begin
                    end_cmd();
                end
                else
                begin
                    sq_sda = sq_shift[7];
                    hold_then(SQ_WR_SCLH);
                end
            end
            SQ_RD_SAMPLE:
            begin
                sq_shift = {sq_shift[6:0], sda};
                sq_scl   = 1'b0;
                hold_then(SQ_RD_NEXT);
            end
            SQ_RD_NEXT:
            begin
                sq_bits = sq_bits + 4'd1;
                if (sq_bits >= 4'd8)
                begin
                    sq_rx = sq_shift;
                    end_cmd();
                end
                else
                begin
                    sq_scl = 1'b1;
                    hold_then(SQ_RD_SAMPLE);
                end
            end
            SQ_WA_SCLH:
            begin
                sq_scl = 1'b1;
                hold_then(SQ_WA_POLLGO);
            end
            SQ_WA_POLLGO:
            begin
                ack_poll(sda);
            end
            SQ_WA_ACKEND:
            begin
                end_cmd();
            end
            SQ_WA_STOPEND:
            begin
                sq_sda = 1'b1;
                end_cmd();
            end
            SQ_AK_SCLH:
            begin
                sq_scl = 1'b1;
                hold_then(SQ_AK_SCLL);
            end
            SQ_AK_SCLL:
            begin
                sq_scl = 1'b0;
                hold_then(SQ_AK_END);
            end
            SQ_AK_END:
            begin
                if (sq_op == OP_ACK)
                begin
                    sq_sda = 1'b1;
                end
                end_cmd();
            end
            default:
            begin
                end_cmd();
            end
        endcase
    endfunction

    // One bus tick: consume a request, return the line/status result.
    function automatic res_item_t sequence_tick(cmd_item_t req);
        res_item_t r;
        sq_done = 1'b0;
        if (sq_state == SQ_IDLE)
        begin
            if (req.cmd_valid && req.opcode != OP_NOP)
            begin
                launch(opcode_t'(req.opcode), req.write_byte);
            end
        end
        else if (sq_state == SQ_WA_POLL)
        begin
            ack_poll(req.sda_in);
        end
        else
        begin
            if (sq_delay > 0)
            begin
                sq_delay--;
            end
            if (sq_delay == 0)
            begin
                advance(req.scl_in, req.sda_in);
            end
        end
        r.scl_out    = sq_scl;
        r.sda_out    = sq_sda;
        r.busy_res   = (sq_state != SQ_IDLE);
        r.done_res   = sq_done;
        r.read_byte  = sq_rx;
        r.ack_seen   = sq_ack;
        r.error_code = sq_err;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, time-0 values of every block input.
    // ------------------------------------------------------------------
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.data   = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.addr   = '0;
        cfg_ch.wdata  = '0;
        fork
            forever #5 clk = ~clk;
        join_none
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop; a correct run needs a few tens of microseconds.
    initial
    begin
        #1ms;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps in between.
    // Each accepted request steps the predictor once.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                expected_lines.push_back(sequence_tick(cmd_ch.data));
                reqs_taken++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.data  <= pending_reqs.pop_front();
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // mostly short bursts, now and then a long unbroken run
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor. Ready follows a stall pattern whose mode is set by
    // stall_clock[7:6]: always ready, light random, periodic, heavy random.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [7:0] seen, logic [7:0] wanted);
        fail_count++;
        if (fail_count <= 100)
        begin
            $display("%0t: result %0d %s: got %0h, want %0h",
                     $time, results_seen, what, seen, wanted);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.data;
                if (expected_lines.size() == 0)
                begin
                    report_mismatch("result with nothing expected", '0, '0);
                end
                else
                begin
                    want = expected_lines.pop_front();
                    if (got.scl_out !== want.scl_out)
                        report_mismatch("scl_out", 8'(got.scl_out), 8'(want.scl_out));
                    if (got.sda_out !== want.sda_out)
                        report_mismatch("sda_out", 8'(got.sda_out), 8'(want.sda_out));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
                    if (got.read_byte !== want.read_byte)
                        report_mismatch("read_byte", got.read_byte, want.read_byte);
                    if (got.ack_seen !== want.ack_seen)
                        report_mismatch("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
                    if (got.error_code !== want.error_code)
                        report_mismatch("error_code", 8'(got.error_code),
                                        8'(want.error_code));
                end
                results_seen++;
            end
            stall_clock <= stall_clock + 32'd1;
            case (stall_clock[7:6])
                2'd0:    res_ch.ready <= 1'b1;
                2'd1:    res_ch.ready <= ($urandom_range(0, 3) != 0);
                2'd2:    res_ch.ready <= (stall_clock[3:1] != 3'b101);
                default: res_ch.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Filler tick: bus levels per line_mode, sometimes a stray command.
    function automatic cmd_item_t filler_req();
        cmd_item_t t;
        int        pick;
        t.cmd_valid  = ($urandom_range(0, 99) < noise_pct);
        t.opcode     = 3'($urandom_range(0, 7));
        t.write_byte = 8'($urandom);
        t.scl_in     = 1'($urandom);
        t.sda_in     = 1'($urandom);
        case (line_mode)
            LN_BUS_IDLE:
            begin
                t.scl_in = 1'b1;
                t.sda_in = 1'b1;
            end
            LN_BUS_LOW:
            begin
                pick     = $urandom_range(0, 2);
                t.scl_in = (pick == 2);
                t.sda_in = (pick == 1);
            end
            LN_ACK_AT:
            begin
                t.scl_in = 1'b1;
                t.sda_in = (tick_no < ack_at);
            end
            default:
            begin
            end
        endcase
        tick_no++;
        return t;
    endfunction

    // Offer one command, then keep fillers flowing until it was taken and
    // the predicted sequencer is back to idle.
    task automatic issue(logic [2:0] code, logic [7:0] wb, line_mode_t mode, int ack_tick);
        cmd_item_t t;
        int        slot;
        line_mode = mode;
        ack_at    = ack_tick;
        tick_no   = 0;
        t            = filler_req();
        t.cmd_valid  = 1'b1;
        t.opcode     = code;
        t.write_byte = wb;
        pending_reqs.push_back(t);
        slot = reqs_pushed;
        reqs_pushed++;
        cmds_issued++;
        do
        begin
            @(negedge clk);
            while (pending_reqs.size() < 3)
            begin
                pending_reqs.push_back(filler_req());
                reqs_pushed++;
            end
        end
        while (reqs_taken <= slot || sq_state != SQ_IDLE);
    endtask

    // Sender holds off until every predicted result has come back and the
    // sequencer is idle (a stray command may still need ticks to finish).
    task automatic drain();
        noise_pct = 0;
        line_mode = LN_FREE;
        do
        begin
            @(negedge clk);
            if (sq_state != SQ_IDLE && pending_reqs.size() < 3)
            begin
                pending_reqs.push_back(filler_req());
                reqs_pushed++;
            end
        end
        while (pending_reqs.size() != 0 || cmd_ch.valid || expected_lines.size() != 0 ||
               sq_state != SQ_IDLE);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.wdata <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_HALF_BIT_DELAY)
            hbd_reg = value;
        else
            ackto_reg = value;
        @(negedge clk);
    endtask

    task automatic set_timing(logic [15:0] hbd, logic [15:0] ato);
        write_reg(REG_HALF_BIT_DELAY, hbd);
        write_reg(REG_ACK_TIMEOUT, ato);
    endtask

    // Tick (counted from the command) at which the slave pulls SDA low;
    // a quarter of the time it never does and the wait-ack times out.
    function automatic int pick_ack();
        int lead;
        lead = 2 * int'(ticks_of(hbd_reg));
        if ($urandom_range(0, 3) == 0)
            return 1 << 24;
        return $urandom_range(0, lead + int'(ticks_of(ackto_reg)) + 1);
    endfunction

    // Mostly a well-formed transfer: start, address, ack, a few data bytes
    // with their acks, stop. Sometimes a lone random command instead.
    task automatic random_transfer();
        logic [2:0] code;
        int         nbytes;
        bit         reading;
        if ($urandom_range(0, 5) == 0)
        begin
            code = 3'($urandom_range(0, 7));
            if (code == OP_START)
                issue(code, 8'($urandom), $urandom_range(0, 1) ? LN_BUS_IDLE : LN_BUS_LOW, 0);
            else if (code == OP_WACK)
                issue(code, 8'($urandom), LN_ACK_AT, pick_ack());
            else
                issue(code, 8'($urandom), LN_FREE, 0);
            return;
        end
        issue(OP_START, 8'($urandom), ($urandom_range(0, 15) == 0) ? LN_BUS_LOW : LN_BUS_IDLE,
              0);
        issue(OP_WRITE, 8'($urandom), LN_FREE, 0);
        issue(OP_WACK, 8'($urandom), LN_ACK_AT, pick_ack());
        reading = 1'($urandom);
        nbytes  = $urandom_range(0, 3);
        for (int j = 0; j < nbytes; j++)
        begin
            if (reading)
            begin
                issue(OP_READ, 8'($urandom), LN_FREE, 0);
                issue((j == nbytes - 1) ? OP_NACK : OP_ACK, 8'($urandom), LN_FREE, 0);
            end
            else
            begin
                issue(OP_WRITE, 8'($urandom), LN_FREE, 0);
                issue(OP_WACK, 8'($urandom), LN_ACK_AT, pick_ack());
            end
        end
        issue(OP_STOP, 8'($urandom), LN_FREE, 0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int goal;
        @(posedge rst_n);
        @(negedge clk);

        // Reset register values: start on an idle bus, then stop.
        issue(OP_START, 8'h00, LN_BUS_IDLE, 0);
        issue(OP_STOP, 8'h00, LN_FREE, 0);
        drain();

        // Fast timing for the directed cases.
        set_timing(16'd1, 16'd4);
        issue(OP_START, 8'h00, LN_BUS_IDLE, 0);
        issue(OP_START, 8'h00, LN_BUS_LOW, 0);      // bus not idle
        issue(OP_WRITE, 8'hFF, LN_FREE, 0);
        issue(OP_WRITE, 8'h00, LN_FREE, 0);
        issue(OP_WRITE, 8'hA5, LN_FREE, 0);
        issue(OP_READ, 8'h00, LN_FREE, 0);
        issue(OP_READ, 8'h00, LN_BUS_IDLE, 0);       // all ones
        issue(OP_WACK, 8'h00, LN_ACK_AT, 0);         // ack at first sample
        issue(OP_WACK, 8'h00, LN_ACK_AT, 1 << 24);   // ack timeout, stop played
        issue(OP_WACK, 8'h00, LN_ACK_AT, 4);         // ack after some polling
        issue(OP_ACK, 8'h00, LN_FREE, 0);
        issue(OP_NACK, 8'h00, LN_FREE, 0);
        issue(OP_STOP, 8'h00, LN_FREE, 0);
        issue(OP_NOP, 8'hFF, LN_FREE, 0);            // invalid opcode
        noise_pct = 60;                              // commands while busy
        issue(OP_WRITE, 8'($urandom), LN_FREE, 0);
        noise_pct = 0;
        issue(OP_STOP, 8'h00, LN_FREE, 0);
        drain();

        // Zero registers behave as one.
        set_timing(16'd0, 16'd0);
        issue(OP_WACK, 8'h00, LN_ACK_AT, 1 << 24);
        issue(OP_WRITE, 8'h5A, LN_FREE, 0);
        issue(OP_START, 8'h00, LN_BUS_IDLE, 0);
        drain();

        // Random transfers over a couple of short timing settings; each
        // phase starts from a drained, idle block.
        for (int p = 0; p < 2; p++)
        begin
            set_timing(16'($urandom_range(1, 2)), 16'($urandom_range(1, 12)));
            noise_pct = $urandom_range(0, 12);
            goal = cmds_issued + 4;
            while (cmds_issued < goal)
            begin
                random_transfer();
            end
            drain();
        end

        if (expected_lines.size() != 0)
        begin
            report_mismatch("results never arrived", 8'(expected_lines.size()), '0);
        end
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ i2c_master_bit_sequencer_core.f @@
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_channels.sv
rtl/core/i2cm_seq.sv
rtl/core/i2c_master_bit_sequencer_core.sv
verif/tb_i2c_master_bit_sequencer_core.sv
